FILE: rtl/core/spd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spd_pkg
// shared constants, command and status types of the serial packet deframer
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int MAX_PAYLOAD_DEF = 16;

    localparam logic [7:0] START_FIRST  = 8'hA5;
    localparam logic [7:0] START_SECOND = 8'h5A;

    localparam logic [4:0] FRAME_LENGTH_RST = 5'd6;
    localparam logic [4:0] OUT_MAX          = 5'd16;

    localparam logic FUNC_BYTE    = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef struct packed {
        logic seed;
        logic add_len;
        logic store;
        logic arm;
        logic release_mbox;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic start_first;
        logic start_second;
        logic len_ok;
        logic fill_done;
        logic sum_ok;
        logic mbox_full;
        logic slot_free;
        logic rd_last;
    } t_status;

endpackage
`default_nettype wire

FILE: rtl/core/spd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spd_if
// item channels of the serial packet deframer
// ----------------------------------------------------------------------------
interface spd_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface spd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [3:0] byte_index;
    logic       is_last;

    modport source (output valid, output payload_byte, output byte_index,
                    output is_last, input ready);
    modport sink   (input valid, input payload_byte, input byte_index,
                    input is_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/spd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spd_ctrl
// frame state machine: start word hunt, seed, length, payload, checksum and drain
// ----------------------------------------------------------------------------
module spd_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    input  wire             i_in_func,
    input  spd_pkg::t_status i_status,
    output logic            o_in_ready,
    output spd_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_HUNT,
        S_SYNC,
        S_SEED,
        S_LEN,
        S_PAYLOAD,
        S_CHECK,
        S_DRAIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept_byte;

    assign o_in_ready  = (r_state != S_DRAIN);
    assign accept_byte = i_in_valid && o_in_ready && (i_in_func == spd_pkg::FUNC_BYTE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.release_mbox = i_in_valid && o_in_ready &&
                             (i_in_func == spd_pkg::FUNC_RELEASE);
        case (r_state)
            S_HUNT: begin
                if (accept_byte) begin
                    n_state = i_status.start_first ? S_SYNC : S_HUNT;
                end
            end
            S_SYNC: begin
                if (accept_byte) begin
                    n_state = i_status.start_second ? S_SEED : S_HUNT;
                end
            end
            S_SEED: begin
                if (accept_byte) begin
                    o_cmd.seed = 1'b1;
                    n_state    = S_LEN;
                end
            end
            S_LEN: begin
                if (accept_byte) begin
                    o_cmd.add_len = 1'b1;
                    n_state       = i_status.len_ok ? S_PAYLOAD : S_HUNT;
                end
            end
            S_PAYLOAD: begin
                if (accept_byte) begin
                    o_cmd.store = 1'b1;
                    if (i_status.fill_done) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (accept_byte) begin
                    if (i_status.sum_ok && !i_status.mbox_full) begin
                        o_cmd.arm = 1'b1;
                        n_state   = S_DRAIN;
                    end else begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_DRAIN: begin
                o_cmd.load = i_status.slot_free;
                if (i_status.slot_free && i_status.rd_last) begin
                    n_state = S_HUNT;
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_payload_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAYLOAD && accept_byte && i_status.fill_done) |=> (r_state == S_CHECK))
        else $error("payload end did not reach checksum");
    a_drain_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && i_status.slot_free && i_status.rd_last) |=> (r_state == S_HUNT))
        else $error("drain did not finish after last read");
    a_arm_needs_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.arm |-> (i_status.sum_ok && !i_status.mbox_full))
        else $error("frame armed with bad checksum or full mailbox");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/spd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spd_dp
// deframer datapath: sum, counters, payload store, mailbox and output register
// ----------------------------------------------------------------------------
module spd_dp #(
    parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire  [4:0]       i_cfg_data,
    input  wire  [7:0]       i_rx_byte,
    input  wire              i_out_ready,
    input  spd_pkg::t_cmd    i_cmd,
    output spd_pkg::t_status o_status,
    output logic             o_out_valid,
    output logic [7:0]       o_payload_byte,
    output logic [3:0]       o_byte_index,
    output logic             o_is_last
);

    localparam int DEPTH = (MAX_PAYLOAD < 16) ? MAX_PAYLOAD : 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0] r_store [DEPTH];
    logic [4:0] r_frame_length;
    logic [4:0] r_frame_len;
    logic [4:0] r_fill;
    logic [7:0] r_sum;
    logic       r_mbox_full;
    logic [3:0] r_rd_idx;
    logic [4:0] r_drain_n;
    logic       r_out_valid;
    logic [7:0] r_payload;
    logic [3:0] r_index;
    logic       r_last;

    logic [5:0] fill_next;
    logic [4:0] rd_next;

    assign fill_next = {1'b0, r_fill} + 6'd1;
    assign rd_next   = {1'b0, r_rd_idx} + 5'd1;

    assign o_status.start_first  = (i_rx_byte == spd_pkg::START_FIRST);
    assign o_status.start_second = (i_rx_byte == spd_pkg::START_SECOND);
    assign o_status.len_ok       = (i_rx_byte != 8'd0) &&
                                   (i_rx_byte == {3'd0, r_frame_length}) &&
                                   ({1'b0, i_rx_byte} <= 9'(MAX_PAYLOAD));
    assign o_status.fill_done    = (fill_next >= {1'b0, r_frame_len});
    assign o_status.sum_ok       = (r_sum == i_rx_byte);
    assign o_status.mbox_full    = r_mbox_full;
    assign o_status.slot_free    = !r_out_valid || i_out_ready;
    assign o_status.rd_last      = (rd_next == r_drain_n);

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_payload;
    assign o_byte_index   = r_index;
    assign o_is_last      = r_last;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= spd_pkg::FRAME_LENGTH_RST;
            r_frame_len    <= 5'd0;
            r_fill         <= 5'd0;
            r_sum          <= 8'd0;
            r_mbox_full    <= 1'b0;
            r_rd_idx       <= 4'd0;
            r_drain_n      <= 5'd0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame_length <= i_cfg_data;
            end
            if (i_cmd.seed) begin
                r_sum <= i_rx_byte;
            end
            if (i_cmd.add_len) begin
                r_sum  <= r_sum + i_rx_byte;
                r_fill <= 5'd0;
                if (o_status.len_ok) begin
                    r_frame_len <= i_rx_byte[4:0];
                end
            end
            if (i_cmd.store) begin
                r_sum  <= r_sum + i_rx_byte;
                r_fill <= fill_next[4:0];
            end
            if (i_cmd.release_mbox) begin
                r_mbox_full <= 1'b0;
            end
            if (i_cmd.arm) begin
                r_mbox_full <= 1'b1;
                r_rd_idx    <= 4'd0;
                r_drain_n   <= (r_frame_len > spd_pkg::OUT_MAX) ? spd_pkg::OUT_MAX
                                                                 : r_frame_len;
            end
            if (i_cmd.load) begin
                r_rd_idx    <= rd_next[3:0];
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload store and registered read into the output item
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && ({1'b0, r_fill} < 6'(DEPTH))) begin
            r_store[r_fill[AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.load) begin
            r_payload <= r_store[r_rd_idx[AW-1:0]];
            r_index   <= r_rd_idx;
            r_last    <= (rd_next == r_frame_len);
        end
    end

`ifndef ASSERT_OFF
    a_load_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> r_mbox_full)
        else $error("payload read without a held frame");
    a_arm_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.arm |-> !r_mbox_full)
        else $error("frame armed while mailbox full");
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.load))
        else $error("output item without a store read");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/serial_packet_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_packet_deframer
// start word hunt, length and additive checksum deframer with one mailbox
// ----------------------------------------------------------------------------
// Each input item (a received byte or a release) is taken when offered, unless
// the input is held off. When a checksum byte completes a good frame and the
// mailbox is empty, the input is held off while the payload, min(length, 16)
// bytes, is read out of the store through its single registered read port, one
// byte per cycle while the output register is free, slower while an item waits
// there. Configuration writes go straight to the frame length register.
module serial_packet_deframer #(
    parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [4:0] i_cfg_data,
    spd_in_if.sink     i_in,
    spd_out_if.source  o_out
);

    spd_pkg::t_cmd    cmd;
    spd_pkg::t_status status;
    logic             in_ready;

    assign i_in.ready = in_ready;

    spd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_func  (i_in.func),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    spd_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_rx_byte      (i_in.rx_byte),
        .i_out_ready    (o_out.ready),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out.valid),
        .o_payload_byte (o_out.payload_byte),
        .o_byte_index   (o_out.byte_index),
        .o_is_last      (o_out.is_last)
    );

endmodule
`default_nettype wire
